/* rtl/xeu_pkg.sv */
// ----------------------------------------------------------------------------
// xeu_pkg
// Shared types, codes and the entity match table of the XML entity unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package xeu_pkg;

	localparam int BYTE_W = 8;
	localparam int PROG_W = 5;
	localparam int ERR_W  = 2;

	localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
	localparam logic [ERR_W-1:0] ERR_ESC  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_RAW  = 2'd2;

	localparam logic [PROG_W-1:0] ST_IDLE = 5'd0;
	localparam logic [PROG_W-1:0] ST_OPEN = 5'd1;
	localparam logic [PROG_W-1:0] ST_Q    = 5'd2;
	localparam logic [PROG_W-1:0] ST_QU   = 5'd3;
	localparam logic [PROG_W-1:0] ST_QUO  = 5'd4;
	localparam logic [PROG_W-1:0] ST_QUOT = 5'd5;
	localparam logic [PROG_W-1:0] ST_L    = 5'd6;
	localparam logic [PROG_W-1:0] ST_LT   = 5'd7;
	localparam logic [PROG_W-1:0] ST_G    = 5'd8;
	localparam logic [PROG_W-1:0] ST_GT   = 5'd9;
	localparam logic [PROG_W-1:0] ST_A    = 5'd10;
	localparam logic [PROG_W-1:0] ST_AM   = 5'd11;
	localparam logic [PROG_W-1:0] ST_AMPS = 5'd12;
	localparam logic [PROG_W-1:0] ST_AP   = 5'd13;
	localparam logic [PROG_W-1:0] ST_APO  = 5'd14;
	localparam logic [PROG_W-1:0] ST_APOS = 5'd15;
	localparam logic [PROG_W-1:0] ST_HASH = 5'd16;
	localparam logic [PROG_W-1:0] ST_HX   = 5'd17;
	localparam logic [PROG_W-1:0] ST_HXA  = 5'd18;
	localparam logic [PROG_W-1:0] ST_HXD  = 5'd19;

	localparam logic [BYTE_W-1:0] CH_AMP   = 8'h26;
	localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
	localparam logic [BYTE_W-1:0] CH_LESS  = 8'h3C;
	localparam logic [BYTE_W-1:0] CH_MORE  = 8'h3E;
	localparam logic [BYTE_W-1:0] CH_APOS  = 8'h27;
	localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
	localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

	typedef struct packed {
		logic              hit;
		logic              done;
		logic [PROG_W-1:0] nxt;
		logic [BYTE_W-1:0] value;
	} edge_t;

	function automatic edge_t trie_step(input logic [PROG_W-1:0] prog,
		input logic [BYTE_W-1:0] b);
		edge_t e;
		e = '{hit: 1'b0, done: 1'b0, nxt: ST_IDLE, value: '0};
		case (prog)
			ST_OPEN: begin
				case (b)
					"q":     e = '{1'b1, 1'b0, ST_Q, 8'h00};
					"l":     e = '{1'b1, 1'b0, ST_L, 8'h00};
					"g":     e = '{1'b1, 1'b0, ST_G, 8'h00};
					"a":     e = '{1'b1, 1'b0, ST_A, 8'h00};
					CH_HASH: e = '{1'b1, 1'b0, ST_HASH, 8'h00};
					default: e = '{1'b0, 1'b0, ST_IDLE, 8'h00};
				endcase
			end
			ST_Q:    if (b == "u") e = '{1'b1, 1'b0, ST_QU, 8'h00};
			ST_QU:   if (b == "o") e = '{1'b1, 1'b0, ST_QUO, 8'h00};
			ST_QUO:  if (b == "t") e = '{1'b1, 1'b0, ST_QUOT, 8'h00};
			ST_QUOT: if (b == CH_SEMI) e = '{1'b1, 1'b1, ST_IDLE, CH_QUOTE};
			ST_L:    if (b == "t") e = '{1'b1, 1'b0, ST_LT, 8'h00};
			ST_LT:   if (b == CH_SEMI) e = '{1'b1, 1'b1, ST_IDLE, CH_LESS};
			ST_G:    if (b == "t") e = '{1'b1, 1'b0, ST_GT, 8'h00};
			ST_GT:   if (b == CH_SEMI) e = '{1'b1, 1'b1, ST_IDLE, CH_MORE};
			ST_A: begin
				if (b == "m") begin
					e = '{1'b1, 1'b0, ST_AM, 8'h00};
				end else if (b == "p") begin
					e = '{1'b1, 1'b0, ST_AP, 8'h00};
				end
			end
			ST_AM:   if (b == "p") e = '{1'b1, 1'b0, ST_AMPS, 8'h00};
			ST_AMPS: if (b == CH_SEMI) e = '{1'b1, 1'b1, ST_IDLE, CH_AMP};
			ST_AP:   if (b == "o") e = '{1'b1, 1'b0, ST_APO, 8'h00};
			ST_APO:  if (b == "s") e = '{1'b1, 1'b0, ST_APOS, 8'h00};
			ST_APOS: if (b == CH_SEMI) e = '{1'b1, 1'b1, ST_IDLE, CH_APOS};
			ST_HASH: if (b == "x") e = '{1'b1, 1'b0, ST_HX, 8'h00};
			ST_HX: begin
				if (b == "a" || b == "A") begin
					e = '{1'b1, 1'b0, ST_HXA, 8'h00};
				end else if (b == "d" || b == "D") begin
					e = '{1'b1, 1'b0, ST_HXD, 8'h00};
				end
			end
			ST_HXA:  if (b == CH_SEMI) e = '{1'b1, 1'b1, ST_IDLE, CH_LF};
			ST_HXD:  if (b == CH_SEMI) e = '{1'b1, 1'b1, ST_IDLE, CH_CR};
			default: e = '{1'b0, 1'b0, ST_IDLE, 8'h00};
		endcase
		return e;
	endfunction

endpackage

`default_nettype wire

/* rtl/xeu_if.sv */
// ----------------------------------------------------------------------------
// xeu_if
// Valid/ready channels for escaped text in and decoded results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface xeu_text_if import xeu_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;
	logic              in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface xeu_result_if import xeu_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              has_byte;
	logic [ERR_W-1:0]  error_code;
	logic              end_of_message;

	modport source (output valid, output out_byte, output has_byte, output error_code,
		output end_of_message, input ready);
	modport sink   (input valid, input out_byte, input has_byte, input error_code,
		input end_of_message, output ready);
endinterface

`default_nettype wire

/* rtl/xml_entity_unescaper_top.sv */
// ----------------------------------------------------------------------------
// xml_entity_unescaper_top
// Streaming XML entity decoder, one escaped byte per transaction.
// ----------------------------------------------------------------------------
// The block takes one escaped byte per clock cycle while the output is not stalled
// and gives at most one result per byte, offered on the output channel from the
// result register: an input register holds the byte, and the entity match state and
// the result register are then updated together when the output can advance. The rate
// of one byte per cycle is set by the update of the match state, which each byte reads
// and writes. While a result waits on the output, one more byte can be held in the
// input register, after which the input stalls until the result is taken.
// Bytes that open or continue an entity, and bytes dropped after an error, give
// no result; the last byte of a message always gives one.
`default_nettype none

module xml_entity_unescaper_top import xeu_pkg::*; (
	input  wire             clk,
	input  wire             arst_n,
	xeu_text_if.sink        text,
	xeu_result_if.source    decoded
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	logic              valid_s2;
	logic [BYTE_W-1:0] obyte_s2;
	logic              has_s2;
	logic [ERR_W-1:0]  err_s2;
	logic              eom_s2;

	logic [PROG_W-1:0] prog_q;
	logic              err_seen_q;

	logic              advance;
	edge_t             e;
	logic              emit;
	logic [BYTE_W-1:0] obyte;
	logic              has;
	logic [ERR_W-1:0]  err;
	logic [PROG_W-1:0] prog_d;
	logic              err_seen_d;

	assign advance    = !valid_s2 || decoded.ready;
	assign text.ready = !valid_s1 || advance;
	assign e          = trie_step(prog_q, byte_s1);

	always_comb begin
		emit       = 1'b0;
		obyte      = '0;
		has        = 1'b0;
		err        = ERR_NONE;
		prog_d     = prog_q;
		err_seen_d = err_seen_q;
		if (err_seen_q) begin
			emit = last_s1;
		end else if (prog_q == ST_IDLE) begin
			if (byte_s1 == CH_AMP) begin
				prog_d = ST_OPEN;
			end else if (byte_s1 == CH_QUOTE || byte_s1 == CH_LESS || byte_s1 == CH_MORE) begin
				err = ERR_RAW;
			end else begin
				obyte = byte_s1;
				has   = 1'b1;
				emit  = 1'b1;
			end
		end else begin
			if (!e.hit) begin
				err = ERR_ESC;
			end else if (e.done) begin
				obyte  = e.value;
				has    = 1'b1;
				emit   = 1'b1;
				prog_d = ST_IDLE;
			end else begin
				prog_d = e.nxt;
			end
		end
		if (last_s1 && !err_seen_q && err == ERR_NONE && prog_d != ST_IDLE) begin
			err = ERR_ESC;
		end
		if (err != ERR_NONE) begin
			emit       = 1'b1;
			err_seen_d = 1'b1;
			prog_d     = ST_IDLE;
			obyte      = '0;
			has        = 1'b0;
		end
		if (last_s1) begin
			prog_d     = ST_IDLE;
			err_seen_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			prog_q     <= ST_IDLE;
			err_seen_q <= 1'b0;
		end else begin
			if (text.ready) begin
				valid_s1 <= text.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1 && emit;
			end
			if (valid_s1 && advance) begin
				prog_q     <= prog_d;
				err_seen_q <= err_seen_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			byte_s1 <= text.in_byte;
			last_s1 <= text.in_last;
		end
		if (advance && valid_s1 && emit) begin
			obyte_s2 <= obyte;
			has_s2   <= has;
			err_s2   <= err;
			eom_s2   <= last_s1;
		end
	end

	assign decoded.valid          = valid_s2;
	assign decoded.out_byte       = obyte_s2;
	assign decoded.has_byte       = has_s2;
	assign decoded.error_code     = err_s2;
	assign decoded.end_of_message = eom_s2;

endmodule

`default_nettype wire

/* rtl/xeu_checker.sv */
// ----------------------------------------------------------------------------
// xeu_checker
// Port-level checks of the XML entity unescaper, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module xeu_checker import xeu_pkg::*; (
	input wire              clk,
	input wire              arst_n,
	input wire              out_valid,
	input wire              out_ready,
	input wire [BYTE_W-1:0] out_byte,
	input wire              has_byte,
	input wire [ERR_W-1:0]  error_code,
	input wire              end_of_message
);

	// An error result never carries a decoded byte.
	a_err_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_NONE |-> !has_byte && out_byte == '0)
		else $error("error result carries a byte");

	// A result without a byte and without an error only closes a message.
	a_empty_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte && error_code == ERR_NONE |-> end_of_message)
		else $error("empty result that does not end a message");

	// Only the defined codes appear: no error and the two error codes.
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> error_code == ERR_NONE || error_code == ERR_ESC ||
			error_code == ERR_RAW)
		else $error("undefined error code");

	// A stalled result holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(has_byte) &&
			$stable(error_code) && $stable(end_of_message))
		else $error("stalled result changed");

endmodule

bind xml_entity_unescaper_top xeu_checker u_xeu_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (decoded.valid),
	.out_ready      (decoded.ready),
	.out_byte       (decoded.out_byte),
	.has_byte       (decoded.has_byte),
	.error_code     (decoded.error_code),
	.end_of_message (decoded.end_of_message)
);

`default_nettype wire

/* dv/xml_entity_unescaper_top_tb.sv */
// ----------------------------------------------------------------------------
// xml_entity_unescaper_top_tb
// Streams escaped text through the XML entity unescaper and checks every
// decoded result against a cycle-free prediction of the entity matcher, under
// random source gaps and sink stalls, a long sink hold-off and error messages.
// ----------------------------------------------------------------------------

module xml_entity_unescaper_top_tb import xeu_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 520;
	localparam int DRAIN_CYCLES = 6;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              has_byte;
		logic [ERR_W-1:0]  error_code;
		logic              end_of_message;
	} decoded_t;

	logic clk = 1'b0;
	logic arst_n;

	xeu_text_if   text_ch ();
	xeu_result_if res_ch ();

	xml_entity_unescaper_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.text    (text_ch),
		.decoded (res_ch)
	);

	always #2 clk = ~clk;

	decoded_t          pending_decoded[$];
	logic [BYTE_W-1:0] msg_buf[$];
	logic [PROG_W-1:0] match_st;
	logic              drop_rest;
	int                fail_count;
	int                sent_items;
	int                send_idle_pct;
	int                recv_idle_pct;
	int                hold_left;
	int                quiet_cycles;

	task automatic report_mismatch(input string what);
		if (fail_count < 100) begin
			$display("mismatch at %0t: %s", $realtime, what);
		end
		fail_count++;
	endtask

	function automatic void entity_walk(input logic [PROG_W-1:0] st,
		input logic [BYTE_W-1:0] b, output logic ok, output logic [PROG_W-1:0] nx,
		output logic [BYTE_W-1:0] val);
		ok = 1'b1;
		nx = ST_IDLE;
		val = '0;
		case ({st, b})
			{ST_OPEN, "q"}:               nx = ST_Q;
			{ST_OPEN, "l"}:               nx = ST_L;
			{ST_OPEN, "g"}:               nx = ST_G;
			{ST_OPEN, "a"}:               nx = ST_A;
			{ST_OPEN, CH_HASH}:           nx = ST_HASH;
			{ST_Q, "u"}:                  nx = ST_QU;
			{ST_QU, "o"}:                 nx = ST_QUO;
			{ST_QUO, "t"}:                nx = ST_QUOT;
			{ST_QUOT, CH_SEMI}:           val = CH_QUOTE;
			{ST_L, "t"}:                  nx = ST_LT;
			{ST_LT, CH_SEMI}:             val = CH_LESS;
			{ST_G, "t"}:                  nx = ST_GT;
			{ST_GT, CH_SEMI}:             val = CH_MORE;
			{ST_A, "m"}:                  nx = ST_AM;
			{ST_A, "p"}:                  nx = ST_AP;
			{ST_AM, "p"}:                 nx = ST_AMPS;
			{ST_AMPS, CH_SEMI}:           val = CH_AMP;
			{ST_AP, "o"}:                 nx = ST_APO;
			{ST_APO, "s"}:                nx = ST_APOS;
			{ST_APOS, CH_SEMI}:           val = CH_APOS;
			{ST_HASH, "x"}:               nx = ST_HX;
			{ST_HX, "a"}, {ST_HX, "A"}:   nx = ST_HXA;
			{ST_HX, "d"}, {ST_HX, "D"}:   nx = ST_HXD;
			{ST_HXA, CH_SEMI}:            val = CH_LF;
			{ST_HXD, CH_SEMI}:            val = CH_CR;
			default:                      ok = 1'b0;
		endcase
	endfunction

	function automatic void predict_decode(input logic [BYTE_W-1:0] b, input logic last);
		decoded_t          r;
		logic              emit;
		logic              ok;
		logic [PROG_W-1:0] nx;
		logic [BYTE_W-1:0] val;
		r = '0;
		r.error_code = ERR_NONE;
		emit = 1'b0;
		if (drop_rest) begin
			emit = last;
		end else if (match_st == ST_IDLE) begin
			if (b == CH_AMP) begin
				match_st = ST_OPEN;
			end else if (b == CH_QUOTE || b == CH_LESS || b == CH_MORE) begin
				r.error_code = ERR_RAW;
			end else begin
				r.out_byte = b;
				r.has_byte = 1'b1;
				emit = 1'b1;
			end
		end else begin
			entity_walk(match_st, b, ok, nx, val);
			if (!ok) begin
				r.error_code = ERR_ESC;
			end else if (nx == ST_IDLE) begin
				r.out_byte = val;
				r.has_byte = 1'b1;
				emit = 1'b1;
				match_st = ST_IDLE;
			end else begin
				match_st = nx;
			end
		end
		if (last && !drop_rest && r.error_code == ERR_NONE && match_st != ST_IDLE) begin
			r.error_code = ERR_ESC;
		end
		if (r.error_code != ERR_NONE) begin
			emit = 1'b1;
			drop_rest = 1'b1;
			match_st = ST_IDLE;
			r.out_byte = '0;
			r.has_byte = 1'b0;
		end
		if (last) begin
			match_st = ST_IDLE;
			drop_rest = 1'b0;
		end
		if (emit) begin
			r.end_of_message = last;
			pending_decoded.push_back(r);
		end
	endfunction

	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			text_ch.valid <= 1'b0;
			@(negedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.in_byte <= b;
		text_ch.in_last <= last;
		@(posedge clk);
		while (!text_ch.ready) begin
			@(posedge clk);
		end
		predict_decode(b, last);
		sent_items++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s, input logic last);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i], last && (i == s.len() - 1));
		end
	endtask

	task automatic send_message();
		for (int i = 0; i < msg_buf.size(); i++) begin
			send_byte(msg_buf[i], i == msg_buf.size() - 1);
		end
	endtask

	task automatic wait_drained();
		text_ch.valid <= 1'b0;
		while (pending_decoded.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic string entity_text(input int unsigned k);
		case (k)
			0:       return "quot;";
			1:       return "lt;";
			2:       return "gt;";
			3:       return "amp;";
			4:       return "apos;";
			5:       return "#xa;";
			6:       return "#xA;";
			7:       return "#xd;";
			default: return "#xD;";
		endcase
	endfunction

	function automatic void add_plain();
		logic [BYTE_W-1:0] b;
		b = BYTE_W'($urandom_range(255));
		while (b == CH_AMP || b == CH_QUOTE || b == CH_LESS || b == CH_MORE) begin
			b = BYTE_W'($urandom_range(255));
		end
		msg_buf.push_back(b);
	endfunction

	function automatic void add_entity(input string s, input int n);
		msg_buf.push_back(CH_AMP);
		for (int i = 0; i < n; i++) begin
			msg_buf.push_back(s[i]);
		end
	endfunction

	task automatic build_message();
		int unsigned kind;
		string       s;
		logic        truncated;
		msg_buf.delete();
		kind = $urandom_range(99);
		truncated = 1'b0;
		if (kind < 15) begin
			repeat ($urandom_range(8, 1)) begin
				if ($urandom_range(3) == 0) begin
					msg_buf.push_back(CH_AMP);
				end else begin
					msg_buf.push_back(BYTE_W'($urandom_range(255)));
				end
			end
		end else begin
			repeat ($urandom_range(12, 1)) begin
				if ($urandom_range(1) == 0) begin
					s = entity_text($urandom_range(8));
					add_entity(s, s.len());
				end else begin
					add_plain();
				end
			end
			if (kind >= 75) begin
				s = entity_text($urandom_range(8));
				case ($urandom_range(2))
					0: begin
						case ($urandom_range(2))
							0:       msg_buf.push_back(CH_QUOTE);
							1:       msg_buf.push_back(CH_LESS);
							default: msg_buf.push_back(CH_MORE);
						endcase
					end
					1: begin
						add_entity(s, $urandom_range(s.len() - 1, 0));
						msg_buf.push_back(BYTE_W'($urandom_range(255)));
					end
					default: begin
						add_entity(s, $urandom_range(s.len() - 1, 0));
						truncated = 1'b1;
					end
				endcase
				if (!truncated) begin
					repeat ($urandom_range(4)) add_plain();
				end
			end
		end
	endtask

	task automatic test_plain_extremes();
		send_byte(8'h00, 1'b0);
		send_byte(CH_APOS, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'hFF, 1'b1);
		wait_drained();
	endtask

	task automatic test_entities();
		send_text("&gt;&#xd;", 1'b1);
		wait_drained();
	endtask

	task automatic test_errors();
		send_text("<ab", 1'b1);
		send_text("&zx", 1'b1);
		send_text("&am", 1'b1);
		send_text("&", 1'b1);
		wait_drained();
	endtask

	task automatic test_random_traffic(input int src_pct, input int dst_pct, input int items);
		int first;
		send_idle_pct = src_pct;
		recv_idle_pct = dst_pct;
		first = sent_items;
		while (sent_items - first < items) begin
			build_message();
			send_message();
		end
		wait_drained();
	endtask

	task automatic test_input_stall();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left = HOLD_CYCLES;
		msg_buf.delete();
		repeat (60) add_plain();
		send_message();
		wait_drained();
	endtask

	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		decoded_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_decoded.size() == 0) begin
				report_mismatch($sformatf("unexpected result byte %02h has %0b err %0d end %0b",
					res_ch.out_byte, res_ch.has_byte, res_ch.error_code, res_ch.end_of_message));
			end else begin
				want = pending_decoded.pop_front();
				if (res_ch.out_byte !== want.out_byte) begin
					report_mismatch($sformatf("out_byte %02h, expected %02h",
						res_ch.out_byte, want.out_byte));
				end
				if (res_ch.has_byte !== want.has_byte) begin
					report_mismatch($sformatf("has_byte %0b, expected %0b",
						res_ch.has_byte, want.has_byte));
				end
				if (res_ch.error_code !== want.error_code) begin
					report_mismatch($sformatf("error_code %0d, expected %0d",
						res_ch.error_code, want.error_code));
				end
				if (res_ch.end_of_message !== want.end_of_message) begin
					report_mismatch($sformatf("end_of_message %0b, expected %0b",
						res_ch.end_of_message, want.end_of_message));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((text_ch.valid && text_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		text_ch.valid = 1'b0;
		text_ch.in_byte = '0;
		text_ch.in_last = 1'b0;
		match_st = ST_IDLE;
		drop_rest = 1'b0;
		fail_count = 0;
		sent_items = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left = 0;
		quiet_cycles = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_plain_extremes();
		test_entities();
		test_errors();
		test_random_traffic(15, 84, PHASE_ITEMS);
		test_random_traffic(84, 15, PHASE_ITEMS);
		test_random_traffic(0, 0, PHASE_ITEMS);
		test_input_stall();
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
